[rtl/anbs_pkg.sv]
// ============================================================================
// anbs_pkg : shared types, constants and functions
// Byte stream splitter constants, report layout and exp-Golomb step logic.
// ============================================================================
package anbs_pkg;

  // Stream limits
  localparam int unsigned OffsetBits   = 32;
  localparam int unsigned MaxUnitBytes = 1048576;
  localparam int unsigned MaxCodeZeros = 31;

  // Field widths
  localparam int unsigned LenBits   = 21;
  localparam int unsigned CntBits   = $clog2(MaxUnitBytes + 2);
  localparam int unsigned ZeroBits  = 6;
  localparam int unsigned InBits    = 8;
  localparam int unsigned OutBits   = 72;

  // Header type codes that carry a slice header
  localparam logic [4:0] UtSlice = 5'd1;
  localparam logic [4:0] UtIdr   = 5'd5;

  // Byte values of interest
  localparam logic [7:0] ByteZero = 8'h00;
  localparam logic [7:0] ByteOne  = 8'h01;

  // Second code may have at most this many leading zeros
  localparam logic [ZeroBits-1:0] SliceTypeZeros = ZeroBits'(3);

  typedef enum logic [2:0] {
    CLS_NONE    = 3'd0,
    CLS_I       = 3'd1,
    CLS_P       = 3'd2,
    CLS_B       = 3'd3,
    CLS_UNKNOWN = 3'd4
  } pic_class_e;

  typedef enum logic [1:0] {
    GP_FIRST  = 2'd0,
    GP_SECOND = 2'd1,
    GP_DONE   = 2'd2
  } golomb_phase_e;

  typedef enum logic [3:0] {
    ST_AWAIT = 4'b0001,
    ST_HUNT  = 4'b0010,
    ST_UNIT  = 4'b0100,
    ST_FLUSH = 4'b1000
  } sync_state_e;

  // Exp-Golomb decoder state
  typedef struct packed {
    golomb_phase_e       phase;
    logic [ZeroBits-1:0] lz;
    logic [ZeroBits-1:0] suffix;
    logic [4:0]          tval;
    pic_class_e          cls;
  } golomb_t;

  localparam golomb_t GolombInit = '{
    phase:  GP_FIRST,
    lz:     '0,
    suffix: '0,
    tval:   '0,
    cls:    CLS_UNKNOWN
  };

  // One input word
  typedef struct packed {
    logic [InBits-1:0] data;
    logic              last;
  } in_item_t;

  // One report
  typedef struct packed {
    logic [31:0]        offset;
    logic [LenBits-1:0] length;
    logic [2:0]         scl;
    logic               forbidden;
    logic [1:0]         ref_idc;
    logic [4:0]         unit_type;
    pic_class_e         pic_class;
    logic               overflow;
    logic               sync_error;
  } rpt_t;

  // slice_type value to picture class
  function automatic pic_class_e slice_class(logic [ZeroBits-1:0] v);
    pic_class_e c;
    case (v)
      6'd0, 6'd3, 6'd5, 6'd8: c = CLS_P;
      6'd1, 6'd6:             c = CLS_B;
      6'd2, 6'd4, 6'd7, 6'd9: c = CLS_I;
      default:                c = CLS_UNKNOWN;
    endcase
    return c;
  endfunction

  // End of one exp-Golomb code
  function automatic golomb_t code_done(golomb_t s);
    golomb_t             n;
    logic [ZeroBits-1:0] v;
    n = s;
    if (s.phase == GP_FIRST) begin
      n.phase = GP_SECOND;
      n.lz    = '0;
    end else begin
      // lz is at most 3 here, tval below 8
      v = ((ZeroBits'(1) << s.lz[1:0]) - ZeroBits'(1)) + ZeroBits'(s.tval);
      n.cls   = slice_class(v);
      n.phase = GP_DONE;
    end
    return n;
  endfunction

  // One bit into the exp-Golomb decoder
  function automatic golomb_t golomb_bit(golomb_t s, logic b);
    golomb_t n;
    n = s;
    if (s.phase == GP_FIRST || s.phase == GP_SECOND) begin
      if (s.suffix == '0) begin
        if (!b) begin
          if (s.lz >= ZeroBits'(MaxCodeZeros) ||
              (s.phase == GP_SECOND && s.lz >= SliceTypeZeros)) begin
            n.cls   = CLS_UNKNOWN;
            n.phase = GP_DONE;
          end else begin
            n.lz = s.lz + ZeroBits'(1);
          end
        end else begin
          n.tval = '0;
          if (s.lz == '0) begin
            n = code_done(n);
          end else begin
            n.suffix = s.lz;
          end
        end
      end else begin
        if (s.phase == GP_SECOND) begin
          n.tval = {s.tval[3:0], b};
        end
        n.suffix = s.suffix - ZeroBits'(1);
        if (n.suffix == '0) begin
          n = code_done(n);
        end
      end
    end
    return n;
  endfunction

  // Unit report from the collected unit state
  function automatic rpt_t make_report(logic [OffsetBits-1:0] start,
                                       logic [CntBits-1:0]    cnt,
                                       logic                  four,
                                       logic [7:0]            hdr,
                                       pic_class_e            cls);
    rpt_t r;
    logic over;
    over         = (cnt > CntBits'(MaxUnitBytes));
    r.offset     = start[31:0];
    r.length     = over ? LenBits'(MaxUnitBytes) : LenBits'(cnt);
    r.scl        = four ? 3'd4 : 3'd3;
    r.forbidden  = hdr[7];
    r.ref_idc    = hdr[6:5];
    r.unit_type  = hdr[4:0];
    r.pic_class  = (hdr[4:0] == UtSlice || hdr[4:0] == UtIdr) ? cls : CLS_NONE;
    r.overflow   = over;
    r.sync_error = 1'b0;
    return r;
  endfunction

  // Sync error report: everything zero but the flag
  function automatic rpt_t sync_report();
    rpt_t r;
    r            = '0;
    r.sync_error = 1'b1;
    return r;
  endfunction

endpackage

[rtl/anbs_golomb.sv]
// ============================================================================
// anbs_golomb : one byte through the exp-Golomb decoder
// Feeds the eight bits of a payload byte, msb first, into the decoder state.
// ============================================================================
module anbs_golomb (
  input  anbs_pkg::golomb_t st_i,
  input  logic [7:0]        byte_i,
  output anbs_pkg::golomb_t st_o
);
  import anbs_pkg::*;

  // Bit-serial walk over the byte, msb first
  always_comb begin
    golomb_t s;
    s = st_i;
    for (int i = 7; i >= 0; i--) begin
      s = golomb_bit(s, byte_i[i]);
    end
    st_o = s;
  end

endmodule

[rtl/anbs_core.sv]
// ============================================================================
// anbs_core : start code tracking and unit bookkeeping
// Handles one byte per cycle while the output is free; drains held payload bytes after a final byte.
// ============================================================================
module anbs_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  anbs_pkg::in_item_t in_item_i,
  input  logic               out_free_i,
  output logic               in_take_o,
  output logic               res_valid_o,
  output anbs_pkg::rpt_t     res_o
);
  import anbs_pkg::*;

  // State registers
  sync_state_e           state_q, state_d;
  logic [23:0]           recent_q, recent_d;
  logic [OffsetBits-1:0] pos_q, pos_d;
  logic [OffsetBits-1:0] start_q, start_d;
  logic [CntBits-1:0]    cnt_q, cnt_d;
  logic                  four_q, four_d;
  logic [7:0]            hdr_q, hdr_d;
  golomb_t               gs_q, gs_d;
  logic [1:0]            held_q, held_d;

  // Start code detection on the incoming byte
  logic                  three, four, sync_bad;
  logic [7:0]            b;
  logic [23:0]           shifted;
  logic [OffsetBits-1:0] open_start;

  assign b          = in_item_i.data;
  assign three      = (b == ByteOne) && (recent_q[15:0] == '0);
  assign four       = three && (recent_q[23:16] == ByteZero);
  assign shifted    = {recent_q[15:0], b};
  assign open_start = pos_q - (four ? OffsetBits'(3) : OffsetBits'(2));
  assign sync_bad   = (pos_q < OffsetBits'(2) && b != ByteZero) ||
                      (pos_q == OffsetBits'(2) && b > ByteOne) ||
                      (pos_q == OffsetBits'(3) && b != ByteOne) ||
                      (pos_q > OffsetBits'(3));

  // Payload byte take: oldest held byte, or the one picked during drain
  logic [7:0]         tb_byte;
  golomb_t            gs_byte, tk_g;
  logic [7:0]         tk_hdr;
  logic [CntBits-1:0] tk_cnt;

  always_comb begin
    case (held_q)
      2'd1:    tb_byte = recent_q[7:0];
      2'd2:    tb_byte = recent_q[15:8];
      default: tb_byte = recent_q[23:16];
    endcase
    if (state_q != ST_FLUSH) begin
      tb_byte = recent_q[23:16];
    end
  end

  anbs_golomb u_golomb (
    .st_i   (gs_q),
    .byte_i (tb_byte),
    .st_o   (gs_byte)
  );

  // First payload byte is the header, the rest feed the decoder
  assign tk_hdr = (cnt_q == '0) ? tb_byte : hdr_q;
  assign tk_g   = (cnt_q == '0) ? gs_q : gs_byte;
  assign tk_cnt = (cnt_q <= CntBits'(MaxUnitBytes)) ? cnt_q + CntBits'(1) : cnt_q;

  // Next state
  always_comb begin
    logic do_open, do_clear, take;
    do_open     = 1'b0;
    do_clear    = 1'b0;
    take        = 1'b0;
    in_take_o   = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    state_d     = state_q;
    recent_d    = recent_q;
    pos_d       = pos_q;
    start_d     = start_q;
    cnt_d       = cnt_q;
    four_d      = four_q;
    hdr_d       = hdr_q;
    gs_d        = gs_q;
    held_d      = held_q;

    case (state_q)
      ST_AWAIT, ST_HUNT: begin
        if (in_valid_i && out_free_i) begin
          in_take_o = 1'b1;
          pos_d     = pos_q + OffsetBits'(1);
          if (state_q == ST_AWAIT && sync_bad) begin
            res_valid_o = 1'b1;
            res_o       = sync_report();
            state_d     = ST_HUNT;
            recent_d    = shifted;
            do_clear    = in_item_i.last;
          end else if (three) begin
            do_open = 1'b1;
            if (in_item_i.last) begin
              // start code on the final byte: empty unit
              res_valid_o = 1'b1;
              res_o       = make_report(open_start, '0, four, '0, CLS_UNKNOWN);
              do_clear    = 1'b1;
            end
          end else begin
            recent_d = shifted;
            if (in_item_i.last) begin
              res_valid_o = (state_q == ST_AWAIT);
              res_o       = sync_report();
              do_clear    = 1'b1;
            end
          end
        end
      end

      ST_UNIT: begin
        if (in_valid_i && out_free_i) begin
          in_take_o = 1'b1;
          pos_d     = pos_q + OffsetBits'(1);
          if (three) begin
            // a lone zero ahead of 00 00 01 still belongs to the payload
            take        = !four && (held_q == 2'd3);
            res_valid_o = 1'b1;
            res_o       = make_report(start_q, take ? tk_cnt : cnt_q, four_q,
                                      take ? tk_hdr : hdr_q,
                                      take ? tk_g.cls : gs_q.cls);
            do_clear    = in_item_i.last;
            do_open     = !in_item_i.last;
          end else begin
            if (held_q == 2'd3) begin
              hdr_d = tk_hdr;
              cnt_d = tk_cnt;
              gs_d  = tk_g;
            end
            recent_d = shifted;
            held_d   = (held_q == 2'd3) ? 2'd3 : held_q + 2'd1;
            if (in_item_i.last) begin
              state_d = ST_FLUSH;
            end
          end
        end
      end

      ST_FLUSH: begin
        // drain held bytes oldest first, report with the last one
        if (out_free_i) begin
          hdr_d  = tk_hdr;
          cnt_d  = tk_cnt;
          gs_d   = tk_g;
          held_d = held_q - 2'd1;
          if (held_q == 2'd1) begin
            res_valid_o = 1'b1;
            res_o       = make_report(start_q, tk_cnt, four_q, tk_hdr, tk_g.cls);
            do_clear    = 1'b1;
          end
        end
      end

      default: begin
        do_clear = 1'b1;
      end
    endcase

    // Open a new unit behind the start code
    if (do_open) begin
      start_d  = open_start;
      four_d   = four;
      cnt_d    = '0;
      hdr_d    = '0;
      gs_d     = GolombInit;
      held_d   = '0;
      recent_d = '1;
      state_d  = ST_UNIT;
    end

    // Back to the post-reset state after the final byte
    if (do_clear) begin
      state_d  = ST_AWAIT;
      recent_d = '1;
      pos_d    = '0;
      start_d  = '0;
      cnt_d    = '0;
      four_d   = 1'b0;
      hdr_d    = '0;
      gs_d     = GolombInit;
      held_d   = '0;
    end
  end

  // Registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_AWAIT;
      recent_q <= '1;
      pos_q    <= '0;
      start_q  <= '0;
      cnt_q    <= '0;
      four_q   <= 1'b0;
      hdr_q    <= '0;
      gs_q     <= GolombInit;
      held_q   <= '0;
    end else begin
      state_q  <= state_d;
      recent_q <= recent_d;
      pos_q    <= pos_d;
      start_q  <= start_d;
      cnt_q    <= cnt_d;
      four_q   <= four_d;
      hdr_q    <= hdr_d;
      gs_q     <= gs_d;
      held_q   <= held_d;
    end
  end

endmodule

[rtl/annexb_nal_unit_splitter_top.sv]
// ============================================================================
// annexb_nal_unit_splitter_top : Annex B start code splitter
// Finds start codes in a byte stream and reports each unit with its header.
// ============================================================================
//
//  Channel  Dir  Word                                         End marker
//  s_axis   in   stream byte                                  tlast = final byte
//  m_axis   out  unit report, tuser = sync error              none
//
//  One byte is taken per cycle while the report register is free. A final
//  byte that closes an open unit holds off the input while the held payload
//  bytes drain through the exp-Golomb stage, one byte each, before the next
//  byte is taken. A byte is registered in the input register, and its
//  report is loaded into the report register from there.
//  Reset (async, active low) puts the splitter in the wait for a first
//  start code. A stalled report holds in the output register; the input
//  register keeps the next byte meanwhile.
//
module annexb_nal_unit_splitter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
  input  logic        s_axis_tlast,
  // reports out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [31:0] unit_offset, [52:32] unit_length,
                                      // [55:53] start_code_length,
                                      // [56] forbidden, [58:57] ref_idc,
                                      // [63:59] unit_type, [66:64] picture_class,
                                      // [67] length_overflow, [71:68] zero
  output logic        m_axis_tuser    // [0] sync_error
);
  import anbs_pkg::*;

  // Input register
  logic     in_valid_q;
  in_item_t in_item_q;
  logic     in_take;

  // Output register
  logic     out_valid_q;
  rpt_t     out_rpt_q;
  logic     out_free;
  logic     res_valid;
  rpt_t     res;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || in_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q <= '{data: s_axis_tdata, last: s_axis_tlast};
    end
  end

  // Splitter core
  anbs_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_q),
    .in_item_i   (in_item_q),
    .out_free_i  (out_free),
    .in_take_o   (in_take),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Report register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_rpt_q <= res;
    end
  end

  // Pack the report word, first field lowest
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000,
                          out_rpt_q.overflow,
                          out_rpt_q.pic_class,
                          out_rpt_q.unit_type,
                          out_rpt_q.ref_idc,
                          out_rpt_q.forbidden,
                          out_rpt_q.scl,
                          out_rpt_q.length,
                          out_rpt_q.offset};
  assign m_axis_tuser  = out_rpt_q.sync_error;

endmodule

[rtl/anbs_checker.sv]
// ============================================================================
// anbs_checker : port level checks for the splitter
// Watches the report stream and its handshake; attached by bind.
// ============================================================================
module anbs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  import anbs_pkg::*;

  // Report fields
  logic [LenBits-1:0] len;
  logic [2:0]         scl;
  logic [4:0]         utype;
  logic [2:0]         pclass;
  logic               ovf;

  assign len    = m_axis_tdata[52:32];
  assign scl    = m_axis_tdata[55:53];
  assign utype  = m_axis_tdata[63:59];
  assign pclass = m_axis_tdata[66:64];
  assign ovf    = m_axis_tdata[67];

  // Stalled report holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("report changed while stalled");

  // Sync error word carries nothing else
  a_sync_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("sync error report with nonzero fields");

  // Unit reports carry a 3 or 4 byte start code
  a_scl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> scl == 3'd3 || scl == 3'd4)
    else $error("bad start code length");

  // Overflow only at the saturated length
  a_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ovf |-> len == LenBits'(MaxUnitBytes))
    else $error("overflow flag without saturated length");

  // Non-slice units have no picture class
  a_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && utype != UtSlice && utype != UtIdr |-> pclass == CLS_NONE)
    else $error("picture class on a non-slice unit");

endmodule

bind annexb_nal_unit_splitter_top anbs_checker u_anbs_checker (.*);

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ============================================================================
// testbench : Annex B start code splitter check
// Streams byte words into the splitter and scores every report against
// a cycle-free model of start code search, header capture and the slice
// header exp-Golomb decode. Covers bad stream starts, empty and short units,
// start codes on the final byte and long output stalls.
// ============================================================================
module testbench;
  import anbs_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandomBytes = 1650;
  localparam int unsigned StallCycles = 300;
  localparam int unsigned DrainGuard = 20000;
  localparam int unsigned SettleCycles = 10;
  localparam int unsigned MaxShown = 10;
  localparam int unsigned IdlePercent = 33;

  // Unit report as seen on m_axis: tdata from the top bit down, then tuser
  typedef struct packed {
    logic [3:0]         pad;
    logic               overflow;
    pic_class_e         pclass;
    logic [4:0]         ntype;
    logic [1:0]         nri;
    logic               forbidden;
    logic [2:0]         code_len;
    logic [LenBits-1:0] length;
    logic [31:0]        offset;
    logic               sync_err;
  } nal_report_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tuser;

  annexb_nal_unit_splitter_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  nal_report_t pending_reports[$];
  int unsigned fail_count = 0;
  int unsigned shown_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycle_count = 0;
  bit          src_idle_on = 1'b1;
  bit          sink_idle_on = 1'b1;
  int unsigned sink_hold_left = 0;

  // Splitter model state
  logic [23:0]   sp_hist;
  logic [31:0]   sp_pos;
  logic [31:0]   sp_start;
  int unsigned   sp_count;
  bit            sp_four;
  logic [7:0]    sp_hdr;
  sync_state_e   sp_sync;
  golomb_phase_e sp_gphase;
  int unsigned   sp_lz;
  int unsigned   sp_suffix;
  logic [4:0]    sp_tval;
  pic_class_e    sp_cls;
  int unsigned   sp_held;

  // --------------------------------------------------------------------------
  // Splitter model
  // --------------------------------------------------------------------------
  task automatic splitter_clear();
    sp_hist   = 24'hFFFFFF;
    sp_pos    = '0;
    sp_start  = '0;
    sp_count  = 0;
    sp_four   = 1'b0;
    sp_hdr    = '0;
    sp_sync   = ST_AWAIT;
    sp_gphase = GP_FIRST;
    sp_lz     = 0;
    sp_suffix = 0;
    sp_tval   = '0;
    sp_cls    = CLS_UNKNOWN;
    sp_held   = 0;
  endtask

  function automatic pic_class_e class_of_slice_type(int unsigned v);
    case (v)
      0, 3, 5, 8: return CLS_P;
      1, 6:       return CLS_B;
      2, 4, 7, 9: return CLS_I;
      default:    return CLS_UNKNOWN;
    endcase
  endfunction

  // first_mb done -> start slice_type; slice_type done -> class
  task automatic finish_golomb_code();
    if (sp_gphase == GP_FIRST) begin
      sp_gphase = GP_SECOND;
      sp_lz     = 0;
    end else begin
      sp_cls    = class_of_slice_type(((1 << sp_lz) - 1) + sp_tval);
      sp_gphase = GP_DONE;
    end
  endtask

  task automatic golomb_step(input bit bt);
    if (sp_gphase != GP_DONE) begin
      if (sp_suffix == 0) begin
        if (!bt) begin
          if (sp_lz >= MaxCodeZeros ||
              (sp_gphase == GP_SECOND && sp_lz >= SliceTypeZeros)) begin
            sp_cls    = CLS_UNKNOWN;
            sp_gphase = GP_DONE;
          end else begin
            sp_lz++;
          end
        end else begin
          sp_tval = '0;
          if (sp_lz == 0) finish_golomb_code();
          else sp_suffix = sp_lz;
        end
      end else begin
        if (sp_gphase == GP_SECOND) sp_tval = {sp_tval[3:0], bt};
        sp_suffix--;
        if (sp_suffix == 0) finish_golomb_code();
      end
    end
  endtask

  // A byte known to be payload: header first, then slice header bits
  task automatic take_payload_byte(input logic [7:0] b);
    if (sp_count == 0) begin
      sp_hdr = b;
    end else begin
      for (int i = 7; i >= 0; i--) golomb_step(b[i]);
    end
    if (sp_count <= MaxUnitBytes) sp_count++;
  endtask

  task automatic open_new_unit(input logic [31:0] p, input bit four);
    sp_start  = four ? p - 32'd3 : p - 32'd2;
    sp_four   = four;
    sp_count  = 0;
    sp_hdr    = '0;
    sp_gphase = GP_FIRST;
    sp_lz     = 0;
    sp_suffix = 0;
    sp_tval   = '0;
    sp_cls    = CLS_UNKNOWN;
    sp_held   = 0;
    sp_hist   = 24'hFFFFFF;
    sp_sync   = ST_UNIT;
  endtask

  function automatic nal_report_t unit_report();
    nal_report_t r;
    r           = '0;
    r.offset    = sp_start;
    r.overflow  = sp_count > MaxUnitBytes;
    r.length    = r.overflow ? LenBits'(MaxUnitBytes) : LenBits'(sp_count);
    r.code_len  = sp_four ? 3'd4 : 3'd3;
    r.forbidden = sp_hdr[7];
    r.nri       = sp_hdr[6:5];
    r.ntype     = sp_hdr[4:0];
    r.pclass    = (r.ntype == UtSlice || r.ntype == UtIdr) ? sp_cls : CLS_NONE;
    return r;
  endfunction

  function automatic nal_report_t sync_error_report();
    nal_report_t r;
    r          = '0;
    r.sync_err = 1'b1;
    return r;
  endfunction

  // One accepted byte word: update the model, queue any report it causes
  task automatic predict_byte(input logic [7:0] b, input bit last);
    logic [31:0] p;
    logic [23:0] h;
    bit          three;
    bit          four;
    bit          bad_start;
    p     = sp_pos;
    h     = sp_hist;
    three = (b == ByteOne) && (h[15:0] == 16'h0000);
    four  = three && (h[23:16] == ByteZero);
    sp_pos = sp_pos + 32'd1;
    if (sp_sync != ST_UNIT) begin
      bad_start = 1'b0;
      if (sp_sync == ST_AWAIT) begin
        bad_start = (p < 2 && b != ByteZero) || (p == 2 && b > ByteOne) ||
                    (p == 3 && b != ByteOne) || p > 3;
      end
      if (bad_start) begin
        pending_reports.push_back(sync_error_report());
        sp_sync = ST_HUNT;
        sp_hist = {h[15:0], b};
        if (last) splitter_clear();
      end else if (three) begin
        open_new_unit(p, four);
        if (last) begin
          pending_reports.push_back(unit_report());
          splitter_clear();
        end
      end else begin
        sp_hist = {h[15:0], b};
        if (last) begin
          if (sp_sync == ST_AWAIT) pending_reports.push_back(sync_error_report());
          splitter_clear();
        end
      end
    end else if (three) begin
      // a lone zero before 00 00 01 is payload, not start code
      if (!four && sp_held == 3) take_payload_byte(h[23:16]);
      pending_reports.push_back(unit_report());
      if (last) splitter_clear();
      else open_new_unit(p, four);
    end else begin
      if (sp_held == 3) take_payload_byte(h[23:16]);
      sp_hist = {h[15:0], b};
      if (sp_held < 3) sp_held++;
      if (last) begin
        for (int i = int'(sp_held) - 1; i >= 0; i--) take_payload_byte(sp_hist[8*i +: 8]);
        pending_reports.push_back(unit_report());
        splitter_clear();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Clock, cycle limit
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("annexb_nal_unit_splitter_top: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Report sink: random stalls, or a counted hold-off when requested
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (sink_hold_left > 0) begin
      m_axis_tready <= 1'b0;
      sink_hold_left <= sink_hold_left - 1;
    end else begin
      m_axis_tready <= !(sink_idle_on && $urandom_range(0, 99) < IdlePercent);
    end
  end

  function automatic string report_text(nal_report_t r);
    return $sformatf({"off=%h len=%0d sc=%0d f=%b nri=%0d type=%0d cls=%0d",
                      " ovf=%b pad=%h serr=%b"},
                     r.offset, r.length, r.code_len, r.forbidden, r.nri, r.ntype,
                     r.pclass, r.overflow, r.pad, r.sync_err);
  endfunction

  function automatic string field_diffs(nal_report_t e, nal_report_t g);
    string s;
    s = "";
    if (g.offset !== e.offset) s = {s, " offset"};
    if (g.length !== e.length) s = {s, " length"};
    if (g.code_len !== e.code_len) s = {s, " code_len"};
    if (g.forbidden !== e.forbidden) s = {s, " forbidden"};
    if (g.nri !== e.nri) s = {s, " ref_idc"};
    if (g.ntype !== e.ntype) s = {s, " type"};
    if (g.pclass !== e.pclass) s = {s, " class"};
    if (g.overflow !== e.overflow) s = {s, " overflow"};
    if (g.pad !== e.pad) s = {s, " pad"};
    if (g.sync_err !== e.sync_err) s = {s, " sync_error"};
    return s;
  endfunction

  // Score each report word against the oldest prediction
  always @(posedge clk_i) begin
    nal_report_t got;
    nal_report_t want;
    string       diffs;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[71:0], m_axis_tuser};
      if (pending_reports.size() == 0) begin
        fail_count++;
        if (shown_count < MaxShown) begin
          shown_count++;
          $display("unexpected report: %s", report_text(got));
        end
      end else begin
        want  = pending_reports.pop_front();
        diffs = field_diffs(want, got);
        if (diffs != "") begin
          fail_count++;
          if (shown_count < MaxShown) begin
            shown_count++;
            $display("report field mismatch:%s", diffs);
            $display("  expected %s", report_text(want));
            $display("  actual   %s", report_text(got));
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stream driver
  // --------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b, input bit last);
    @(negedge clk_i);
    while (src_idle_on && $urandom_range(0, 99) < IdlePercent) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_stream(input logic [7:0] q[$]);
    for (int i = 0; i < q.size(); i++) push_byte(q[i], i == q.size() - 1);
  endtask

  // Wait for every predicted report, then let the pipeline settle
  task automatic drain_reports();
    int unsigned guard;
    guard = 0;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0 && guard < DrainGuard) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [7:0] payload_byte();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r < 3) return ByteZero;
    if (r == 3) return ByteOne;
    return 8'($urandom_range(0, 255));
  endfunction

  // Stream of short units with random headers and payload, now and then behind junk bytes
  task automatic send_unit_stream();
    logic [7:0]  q[$];
    logic [7:0]  hdr;
    int unsigned plen;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(0, 255)));
    end
    repeat ($urandom_range(1, 5)) begin
      if ($urandom_range(0, 2) == 0) q.push_back(ByteZero);
      q.push_back(ByteZero);
      q.push_back(ByteZero);
      q.push_back(ByteOne);
      if ($urandom_range(0, 1) == 0) begin
        hdr = {1'($urandom_range(0, 15) == 0), 2'($urandom_range(0, 3)),
               ($urandom_range(0, 1) == 0) ? UtSlice : UtIdr};
      end else begin
        hdr = 8'($urandom_range(0, 255));
      end
      if ($urandom_range(0, 9) != 0) q.push_back(hdr);
      // deep leading zero run in first_mb now and then
      if ($urandom_range(0, 15) == 0) begin
        repeat ($urandom_range(3, 5)) q.push_back(ByteZero);
        q.push_back(8'($urandom_range(2, 255)));
      end
      plen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 48) : $urandom_range(0, 6);
      repeat (plen) q.push_back(payload_byte());
    end
    // stream may close on a start code
    if ($urandom_range(0, 7) == 0) begin
      q.push_back(ByteZero);
      q.push_back(ByteZero);
      q.push_back(ByteOne);
    end
    send_stream(q);
  endtask

  // Noise heavy in zeros and ones, sometimes behind a valid start code
  task automatic send_noise_stream();
    logic [7:0]  q[$];
    int unsigned r;
    if ($urandom_range(0, 9) < 3) begin
      q.push_back(ByteZero);
      q.push_back(ByteZero);
      q.push_back(ByteOne);
    end
    repeat ($urandom_range(1, 20)) begin
      r = $urandom_range(0, 15);
      if (r < 5) q.push_back(ByteZero);
      else if (r < 7) q.push_back(ByteOne);
      else q.push_back(8'($urandom_range(0, 255)));
    end
    send_stream(q);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed_cases();
    // stream ends before any start code
    send_stream('{8'h00, 8'h00});
    // bad first byte, hunt ends without a start code
    send_stream('{8'h7F, 8'h12});
    // 4-byte code IDR I slice, empty unit, slice with slice_type too deep,
    // then start code on the final byte closes the open unit
    send_stream('{8'h00, 8'h00, 8'h00, 8'h01, 8'hE5, 8'h88, 8'h00, 8'h00, 8'h01,
                  8'h00, 8'h00, 8'h01, 8'h41, 8'h84, 8'h00, 8'h00, 8'h01});
    // start code on the final byte with no unit open
    send_stream('{8'h00, 8'h00, 8'h01});
    // forbidden bit set, B slice, held bytes drain on the final byte
    send_stream('{8'h00, 8'h00, 8'h01, 8'hE1, 8'hA0, 8'hC0});
    drain_reports();
  endtask

  // Sink holds off while short units keep coming, then everything drains
  task automatic test_output_stall();
    logic [7:0] q[$];
    src_idle_on    = 1'b0;
    sink_hold_left = StallCycles;
    repeat (40) begin
      q.push_back(ByteZero);
      q.push_back(ByteZero);
      q.push_back(ByteOne);
      q.push_back(8'($urandom_range(0, 255)));
    end
    send_stream(q);
    drain_reports();
    src_idle_on = 1'b1;
  endtask

  task automatic test_random_streams();
    int unsigned first;
    bit          calm;
    first = bytes_sent;
    while (bytes_sent < first + RandomBytes) begin
      calm         = bytes_sent > first + 700 && bytes_sent < first + 1000;
      src_idle_on  = !calm;
      sink_idle_on = !calm;
      if ($urandom_range(0, 4) == 0) send_noise_stream();
      else send_unit_stream();
    end
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    drain_reports();
  endtask

  initial begin
    splitter_clear();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_output_stall();
    test_random_streams();
    drain_reports();
    if (pending_reports.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("annexb_nal_unit_splitter_top: match");
    end else begin
      $display("annexb_nal_unit_splitter_top: mismatch");
    end
    $finish;
  end

endmodule

[annexb_nal_unit_splitter_top.f]
rtl/anbs_pkg.sv
rtl/anbs_golomb.sv
rtl/anbs_core.sv
rtl/annexb_nal_unit_splitter_top.sv
rtl/anbs_checker.sv
tb/sv/testbench.sv
